@@ rtl/core/msc_pkg.sv @@
// ----------------------------------------------------------------------------
// msc_pkg: shared types and constants of the masked byte pattern scanner
// Beat layouts, configuration register indexes and sizing constants.
// ----------------------------------------------------------------------------
package msc_pkg;

  localparam int MAX_PATTERN = 16;
  localparam int WIN_DEPTH   = 16;
  localparam int WIN_IDX_W   = $clog2(WIN_DEPTH);
  localparam int LEN_W       = 5;
  localparam int OFFSET_BITS = 32;
  localparam int OFS_OUT_W   = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] WILDCARD_MASK = 8'h00;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAT_LO  = 3'd0,
    CFG_PAT_HI  = 3'd1,
    CFG_MASK_LO = 3'd2,
    CFG_MASK_HI = 3'd3,
    CFG_LEN     = 3'd4
  } msc_cfg_idx_t;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       last_byte;
  } msc_in_t;

  typedef struct packed {
    logic                 found;
    logic [OFS_OUT_W-1:0] match_offset;
  } msc_out_t;

  typedef struct packed {
    logic full;
    logic empty;
  } msc_fifo_stat_t;

endpackage

@@ rtl/core/msc_front.sv @@
// ----------------------------------------------------------------------------
// msc_front: window, byte count and match evaluation
// Holds the configuration, takes one stream byte per beat, and pushes a
// result per stream into the queue: on the first match, else on the last byte.
// ----------------------------------------------------------------------------
module msc_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  msc_pkg::msc_in_t              in_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [msc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [msc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  msc_pkg::msc_fifo_stat_t       fifo_stat,
  output logic                          push_valid,
  output msc_pkg::msc_out_t             push_data
);
  import msc_pkg::*;

  logic [63:0]            pat_lo_r, pat_hi_r, mask_lo_r, mask_hi_r;
  logic [127:0]           pat_all, mask_all;
  logic [LEN_W-1:0]       len_r;
  logic [7:0]             win_r   [WIN_DEPTH];
  logic [7:0]             win_nxt [WIN_DEPTH];
  logic [OFFSET_BITS-1:0] cnt_r, cnt_nxt;
  logic                   done_r, done_nxt;
  logic                   accept;
  logic [LEN_W-1:0]       len_eff;
  logic                   all_ok, hit;
  logic [OFFSET_BITS-1:0] ofs_full;

  assign cfg_ready = 1'b1;
  assign in_ready  = !fifo_stat.full;
  assign accept    = in_valid && in_ready;
  assign len_eff   = (len_r > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : len_r;
  assign pat_all   = {pat_hi_r, pat_lo_r};
  assign mask_all  = {mask_hi_r, mask_lo_r};

  always_comb begin
    win_nxt[0] = in_data.stream_byte;
    for (int i = 1; i < WIN_DEPTH; i++) begin
      win_nxt[i] = win_r[i-1];
    end
    cnt_nxt = (cnt_r == {OFFSET_BITS{1'b1}}) ? cnt_r : cnt_r + OFFSET_BITS'(1);
  end

  // Pattern byte j lines up with window entry len-1-j (entry 0 is newest).
  always_comb begin
    logic [WIN_IDX_W-1:0] idx;
    logic [7:0]           m, p, s;
    all_ok = 1'b1;
    idx    = '0;
    m      = '0;
    p      = '0;
    s      = '0;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      m   = mask_all[8*j +: 8];
      p   = pat_all[8*j +: 8];
      idx = WIN_IDX_W'(len_eff - LEN_W'(j) - LEN_W'(1));
      s   = win_nxt[idx];
      if (LEN_W'(j) < len_eff && m != WILDCARD_MASK && ((s ^ p) & m) != 8'h00) begin
        all_ok = 1'b0;
      end
    end
  end

  assign hit      = !done_r && (len_eff != '0) && (cnt_nxt >= OFFSET_BITS'(len_eff)) && all_ok;
  assign ofs_full = cnt_nxt - OFFSET_BITS'(len_eff);

  assign push_valid             = accept && (hit || (in_data.last_byte && !done_r));
  assign push_data.found        = hit;
  assign push_data.match_offset = hit ? ofs_full[OFS_OUT_W-1:0] : '0;
  assign done_nxt               = done_r || hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r  <= '0;
      pat_hi_r  <= '0;
      mask_lo_r <= '0;
      mask_hi_r <= '0;
      len_r     <= LEN_W'(1);
      cnt_r     <= '0;
      done_r    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (msc_cfg_idx_t'(cfg_index))
          CFG_PAT_LO:  pat_lo_r  <= cfg_data;
          CFG_PAT_HI:  pat_hi_r  <= cfg_data;
          CFG_MASK_LO: mask_lo_r <= cfg_data;
          CFG_MASK_HI: mask_hi_r <= cfg_data;
          CFG_LEN:     len_r     <= cfg_data[LEN_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        if (in_data.last_byte) begin
          cnt_r  <= '0;
          done_r <= 1'b0;
        end else begin
          cnt_r  <= cnt_nxt;
          done_r <= done_nxt;
        end
      end
    end
  end

  // The window needs no reset: the byte count keeps stale entries out of a match.
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < WIN_DEPTH; i++) begin
        win_r[i] <= win_nxt[i];
      end
    end
  end

endmodule

@@ rtl/core/msc_fifo.sv @@
// ----------------------------------------------------------------------------
// msc_fifo: result queue between front and back
// A small register queue that lets the front keep scanning while the back
// waits on the consumer.
// ----------------------------------------------------------------------------
module msc_fifo (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push_valid,
  input  msc_pkg::msc_out_t       push_data,
  input  logic                    pop,
  output msc_pkg::msc_out_t       pop_data,
  output msc_pkg::msc_fifo_stat_t stat
);
  import msc_pkg::*;

  msc_out_t              mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  do_push, do_pop;

  assign stat.full  = (cnt_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push_valid && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_data   = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + FIFO_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) wr_ptr_r <= wr_ptr_r + FIFO_PTR_W'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + FIFO_PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ rtl/core/msc_back.sv @@
// ----------------------------------------------------------------------------
// msc_back: result output stage
// Pulls results from the queue into a registered output beat.
// ----------------------------------------------------------------------------
module msc_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  msc_pkg::msc_fifo_stat_t fifo_stat,
  input  msc_pkg::msc_out_t       pop_data,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output msc_pkg::msc_out_t       out_data
);
  import msc_pkg::*;

  logic     valid_r;
  msc_out_t data_r;

  assign pop       = !fifo_stat.empty && (!valid_r || out_ready);
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      data_r <= pop_data;
    end
  end

endmodule

@@ rtl/core/masked_byte_pattern_scanner_top.sv @@
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner_top: masked byte pattern search over a stream
// Top level tying the scanning front, the result queue and the output stage.
// ----------------------------------------------------------------------------
// The scanner takes one stream byte per clock cycle and searches for the
// first place where a pattern of up to 16 bytes matches under a per-byte
// mask (a zero mask byte is a wildcard). Each input beat is evaluated in the
// cycle it is accepted: the sliding window shift, the sixteen parallel masked
// byte compares and the saturating byte count all sit in the front, so the
// sustained rate is one byte per cycle. A stream gives exactly one result
// beat: found with the start offset on the first complete match, or not
// found on the beat that carries last_byte when no match was seen. Results
// pass through a four-entry queue and a registered output beat, so the input
// keeps flowing while the consumer stalls; input ready drops only when the
// queue is full. A result is written into the queue when the byte that
// caused it is accepted, and is then registered into the output beat.
// Configuration writes are always accepted and must be issued only while the
// scanner is idle.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scanner_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  msc_pkg::msc_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output msc_pkg::msc_out_t              out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [msc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [msc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import msc_pkg::*;

  msc_fifo_stat_t fifo_stat;
  logic           push_valid;
  msc_out_t       push_data;
  logic           pop;
  msc_out_t       pop_data;

  // Front: configuration, window, count and match decision.
  msc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fifo_stat  (fifo_stat),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  // Queue that decouples scanning from result delivery.
  msc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .pop        (pop),
    .pop_data   (pop_data),
    .stat       (fifo_stat)
  );

  // Back: registered output beat.
  msc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .fifo_stat (fifo_stat),
    .pop_data  (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
